/* hdl/closest_point_on_triangle_core_defines.svh */
// Assertion macros shared by the closest point block.
`ifndef CLOSEST_POINT_ON_TRIANGLE_CORE_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cpt_pkg.sv */
package cpt_pkg;

    // Coordinate format.
    localparam int CIB = 8;
    localparam int CFB = 16;
    localparam int CW  = CIB + CFB;

    // Widths of the intermediate values.
    localparam int WD   = CW + 1;          // coordinate difference
    localparam int WPR  = 2 * WD;          // one product of differences
    localparam int WDOT = WPR + 2;         // dot product
    localparam int WT   = WDOT + 1;        // difference of two dot products
    localparam int WBIG = 2 * WDOT + 1;    // cross term
    localparam int WN   = WBIG + 2;        // ratio numerator, denominator, remainder
    localparam int QB   = CFB + 1;         // ratio bits, one integer bit
    localparam int WM   = QB + 1 + WD;     // ratio times edge
    localparam int WS   = WM + 3;          // sum before rounding
    localparam int HB   = WDOT / 2;        // half a dot product, for the split cross-term multiply
    localparam int WPP  = 2 * (HB + 1);    // one partial product of the halves

    // Pipeline stage positions.
    localparam int ST_DV0 = 6;
    localparam int ST_MUL = ST_DV0 + QB + 1;
    localparam int ST_OUT = ST_MUL + 1;
    localparam int NST    = ST_OUT + 1;

    localparam logic signed [WS-1:0] SAT_HI = {{(WS-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [WS-1:0] SAT_LO = {{(WS-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [WS-1:0] RND_HALF = {{(WS-CFB){1'b0}}, 1'b1, {(CFB-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_C    = 3'd2,
        REG_AB   = 3'd3,
        REG_AC   = 3'd4,
        REG_BC   = 3'd5,
        REG_FACE = 3'd6
    } t_region;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [WD-1:0] x;
        logic signed [WD-1:0] y;
        logic signed [WD-1:0] z;
    } t_dvec;

    typedef struct packed {
        logic signed [WPR-1:0] x;
        logic signed [WPR-1:0] y;
        logic signed [WPR-1:0] z;
    } t_pvec;

    typedef struct packed {
        logic signed [WM-1:0] x;
        logic signed [WM-1:0] y;
        logic signed [WM-1:0] z;
    } t_mvec;

    // u - v, one bit wider.
    function automatic t_dvec vsub(input t_vec u, input t_vec v);
        t_dvec r;
        r.x = WD'(u.x) - WD'(v.x);
        r.y = WD'(u.y) - WD'(v.y);
        r.z = WD'(u.z) - WD'(v.z);
        return r;
    endfunction

    // Round to nearest (ties up), drop the fraction, clamp to the format.
    function automatic logic signed [CW-1:0] sat_round(input logic signed [WS-1:0] v);
        logic signed [WS-1:0] s;
        s = (v + RND_HALF) >>> CFB;
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[CW-1:0];
    endfunction

endpackage

/* hdl/cpt_item_if.sv */
interface cpt_item_if;
    logic                          valid;
    logic                          ready;
    logic signed [cpt_pkg::CW-1:0] point_x;
    logic signed [cpt_pkg::CW-1:0] point_y;
    logic signed [cpt_pkg::CW-1:0] point_z;
    logic signed [cpt_pkg::CW-1:0] vert_a_x;
    logic signed [cpt_pkg::CW-1:0] vert_a_y;
    logic signed [cpt_pkg::CW-1:0] vert_a_z;
    logic signed [cpt_pkg::CW-1:0] vert_b_x;
    logic signed [cpt_pkg::CW-1:0] vert_b_y;
    logic signed [cpt_pkg::CW-1:0] vert_b_z;
    logic signed [cpt_pkg::CW-1:0] vert_c_x;
    logic signed [cpt_pkg::CW-1:0] vert_c_y;
    logic signed [cpt_pkg::CW-1:0] vert_c_z;

    modport source (
        output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

/* hdl/cpt_res_if.sv */
interface cpt_res_if;
    logic                          valid;
    logic                          ready;
    logic signed [cpt_pkg::CW-1:0] near_x;
    logic signed [cpt_pkg::CW-1:0] near_y;
    logic signed [cpt_pkg::CW-1:0] near_z;
    logic [2:0]                    region;
    logic                          degenerate;

    modport source (
        output valid, near_x, near_y, near_z, region, degenerate,
        input  ready
    );

    modport sink (
        input  valid, near_x, near_y, near_z, region, degenerate,
        output ready
    );
endinterface

/* hdl/closest_point_on_triangle_core.sv */
// Channel   Direction  Contents
// i_item    in         query point and the three vertices, signed Q8.16
// o_res     out        closest point, region code, degenerate flag
//
// One item per cycle is accepted while the first stage can load; the path from acceptance to
// its result is mostly made up of the 17 restoring divider steps of the edge and face ratios.
// Each stage holds its own valid bit and stalls only when the stage after it is full,
// so bubbles close up and a waiting result does not block new items.
// The synchronous reset clears the valid bits only; the data registers are not reset.
`include "closest_point_on_triangle_core_defines.svh"

module closest_point_on_triangle_core (
    input logic        i_clk,
    input logic        i_rst_n,
    cpt_item_if.sink   i_item,
    cpt_res_if.source  o_res
);
    import cpt_pkg::*;

    typedef struct packed {
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec bc;
        t_dvec ap;
        t_dvec bp;
        t_dvec cp;
    } t_s1;

    typedef struct packed {
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec bc;
        t_pvec pd1;
        t_pvec pd2;
        t_pvec pd3;
        t_pvec pd4;
        t_pvec pd5;
        t_pvec pd6;
    } t_s2;

    typedef struct packed {
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec bc;
        logic signed [WDOT-1:0] d1;
        logic signed [WDOT-1:0] d2;
        logic signed [WDOT-1:0] d3;
        logic signed [WDOT-1:0] d4;
        logic signed [WDOT-1:0] d5;
        logic signed [WDOT-1:0] d6;
    } t_s3;

    // Four partial products of one dot-product pair, split at bit HB.
    typedef struct packed {
        logic signed [WPP-1:0] hh;
        logic signed [WPP-1:0] hl;
        logic signed [WPP-1:0] lh;
        logic signed [WPP-1:0] ll;
    } t_pp;

    typedef struct packed {
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec bc;
        logic signed [WDOT-1:0] d1;
        logic signed [WDOT-1:0] d2;
        logic signed [WDOT-1:0] d3;
        logic signed [WDOT-1:0] d4;
        logic signed [WDOT-1:0] d5;
        logic signed [WDOT-1:0] d6;
        t_pp p14;
        t_pp p32;
        t_pp p52;
        t_pp p16;
        t_pp p36;
        t_pp p54;
    } t_s4p;

    typedef struct packed {
        t_vec  a;
        t_vec  b;
        t_dvec ab;
        t_dvec ac;
        t_dvec bc;
        t_vec  c;
        logic signed [WDOT-1:0] d1;
        logic signed [WDOT-1:0] d2;
        logic signed [WDOT-1:0] d3;
        logic signed [WDOT-1:0] d4;
        logic signed [WDOT-1:0] d5;
        logic signed [WDOT-1:0] d6;
        logic signed [WBIG-1:0] m14;
        logic signed [WBIG-1:0] m32;
        logic signed [WBIG-1:0] m52;
        logic signed [WBIG-1:0] m16;
        logic signed [WBIG-1:0] m36;
        logic signed [WBIG-1:0] m54;
    } t_s4;

    typedef struct packed {
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec bc;
        logic signed [WDOT-1:0] d1;
        logic signed [WDOT-1:0] d2;
        logic signed [WDOT-1:0] d3;
        logic signed [WDOT-1:0] d6;
        logic signed [WT-1:0]   t43;
        logic signed [WT-1:0]   t56;
        logic signed [WBIG-1:0] va;
        logic signed [WBIG-1:0] vb;
        logic signed [WBIG-1:0] vc;
    } t_s5;

    typedef struct packed {
        t_region         region;
        logic            deg;
        t_vec            base;
        t_dvec           e1;
        t_dvec           e2;
        logic [WN-1:0]   den;
        logic [WN-1:0]   rem1;
        logic [WN-1:0]   rem2;
        logic [QB-1:0]   q1;
        logic [QB-1:0]   q2;
    } t_dv;

    typedef struct packed {
        t_region region;
        logic    deg;
        t_vec    base;
        t_mvec   p1;
        t_mvec   p2;
    } t_ml;

    typedef struct packed {
        t_region region;
        logic    deg;
        t_vec    near;
    } t_out;

    // One restoring step on both ratios: shift the remainder if shift is set, then compare and subtract.
    function automatic t_dv div_step(input t_dv x, input logic shift);
        t_dv           y;
        logic [WN-1:0] r1;
        logic [WN-1:0] r2;
        y  = x;
        r1 = shift ? {x.rem1[WN-2:0], 1'b0} : x.rem1;
        r2 = shift ? {x.rem2[WN-2:0], 1'b0} : x.rem2;
        if (r1 >= x.den) begin
            y.rem1 = r1 - x.den;
            y.q1   = {x.q1[QB-2:0], 1'b1};
        end else begin
            y.rem1 = r1;
            y.q1   = {x.q1[QB-2:0], 1'b0};
        end
        if (r2 >= x.den) begin
            y.rem2 = r2 - x.den;
            y.q2   = {x.q2[QB-2:0], 1'b1};
        end else begin
            y.rem2 = r2;
            y.q2   = {x.q2[QB-2:0], 1'b0};
        end
        return y;
    endfunction

    // Split both dot products into a signed high half and an unsigned low half, and form the four partial products.
    function automatic t_pp split_mul(input logic signed [WDOT-1:0] u,
                                      input logic signed [WDOT-1:0] v);
        t_pp                  r;
        logic signed [HB-1:0] uh;
        logic signed [HB-1:0] vh;
        logic signed [HB:0]   ul;
        logic signed [HB:0]   vl;
        uh   = u[WDOT-1:HB];
        vh   = v[WDOT-1:HB];
        ul   = $signed({1'b0, u[HB-1:0]});
        vl   = $signed({1'b0, v[HB-1:0]});
        r.hh = WPP'(uh) * WPP'(vh);
        r.hl = WPP'(uh) * WPP'(vl);
        r.lh = WPP'(ul) * WPP'(vh);
        r.ll = WPP'(ul) * WPP'(vl);
        return r;
    endfunction

    // Weight and add the four partial products into the full product.
    function automatic logic signed [WBIG-1:0] join_pp(input t_pp p);
        return (WBIG'(p.hh) <<< (2 * HB)) + ((WBIG'(p.hl) + WBIG'(p.lh)) <<< HB)
               + WBIG'(p.ll);
    endfunction

    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s4p r_s4p, n_s4p;
    t_s4  r_s4, n_s4;
    t_s5  r_s5, n_s5;
    t_dv  r_dv [QB+1];
    t_dv  n_dv [QB+1];
    t_ml  r_ml, n_ml;
    t_out r_out, n_out;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        en[NST-1] = !r_vld[NST-1] || o_res.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_item.ready = en[0];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_item.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: take the item and form the edge and offset vectors.
    always_comb begin
        n_s1.a  = '{x: i_item.vert_a_x, y: i_item.vert_a_y, z: i_item.vert_a_z};
        n_s1.b  = '{x: i_item.vert_b_x, y: i_item.vert_b_y, z: i_item.vert_b_z};
        n_s1.c  = '{x: i_item.vert_c_x, y: i_item.vert_c_y, z: i_item.vert_c_z};
        n_s1.ab = vsub(n_s1.b, n_s1.a);
        n_s1.ac = vsub(n_s1.c, n_s1.a);
        n_s1.bc = vsub(n_s1.c, n_s1.b);
        n_s1.ap = vsub('{x: i_item.point_x, y: i_item.point_y, z: i_item.point_z}, n_s1.a);
        n_s1.bp = vsub('{x: i_item.point_x, y: i_item.point_y, z: i_item.point_z}, n_s1.b);
        n_s1.cp = vsub('{x: i_item.point_x, y: i_item.point_y, z: i_item.point_z}, n_s1.c);
    end

    // Stage 2: the eighteen component products of the six dot products.
    always_comb begin
        n_s2.a  = r_s1.a;
        n_s2.b  = r_s1.b;
        n_s2.c  = r_s1.c;
        n_s2.ab = r_s1.ab;
        n_s2.ac = r_s1.ac;
        n_s2.bc = r_s1.bc;
        n_s2.pd1.x = WPR'(r_s1.ab.x) * WPR'(r_s1.ap.x);
        n_s2.pd1.y = WPR'(r_s1.ab.y) * WPR'(r_s1.ap.y);
        n_s2.pd1.z = WPR'(r_s1.ab.z) * WPR'(r_s1.ap.z);
        n_s2.pd2.x = WPR'(r_s1.ac.x) * WPR'(r_s1.ap.x);
        n_s2.pd2.y = WPR'(r_s1.ac.y) * WPR'(r_s1.ap.y);
        n_s2.pd2.z = WPR'(r_s1.ac.z) * WPR'(r_s1.ap.z);
        n_s2.pd3.x = WPR'(r_s1.ab.x) * WPR'(r_s1.bp.x);
        n_s2.pd3.y = WPR'(r_s1.ab.y) * WPR'(r_s1.bp.y);
        n_s2.pd3.z = WPR'(r_s1.ab.z) * WPR'(r_s1.bp.z);
        n_s2.pd4.x = WPR'(r_s1.ac.x) * WPR'(r_s1.bp.x);
        n_s2.pd4.y = WPR'(r_s1.ac.y) * WPR'(r_s1.bp.y);
        n_s2.pd4.z = WPR'(r_s1.ac.z) * WPR'(r_s1.bp.z);
        n_s2.pd5.x = WPR'(r_s1.ab.x) * WPR'(r_s1.cp.x);
        n_s2.pd5.y = WPR'(r_s1.ab.y) * WPR'(r_s1.cp.y);
        n_s2.pd5.z = WPR'(r_s1.ab.z) * WPR'(r_s1.cp.z);
        n_s2.pd6.x = WPR'(r_s1.ac.x) * WPR'(r_s1.cp.x);
        n_s2.pd6.y = WPR'(r_s1.ac.y) * WPR'(r_s1.cp.y);
        n_s2.pd6.z = WPR'(r_s1.ac.z) * WPR'(r_s1.cp.z);
    end

    // Stage 3: sum the products into d1 to d6.
    always_comb begin
        n_s3.a  = r_s2.a;
        n_s3.b  = r_s2.b;
        n_s3.c  = r_s2.c;
        n_s3.ab = r_s2.ab;
        n_s3.ac = r_s2.ac;
        n_s3.bc = r_s2.bc;
        n_s3.d1 = WDOT'(r_s2.pd1.x) + WDOT'(r_s2.pd1.y) + WDOT'(r_s2.pd1.z);
        n_s3.d2 = WDOT'(r_s2.pd2.x) + WDOT'(r_s2.pd2.y) + WDOT'(r_s2.pd2.z);
        n_s3.d3 = WDOT'(r_s2.pd3.x) + WDOT'(r_s2.pd3.y) + WDOT'(r_s2.pd3.z);
        n_s3.d4 = WDOT'(r_s2.pd4.x) + WDOT'(r_s2.pd4.y) + WDOT'(r_s2.pd4.z);
        n_s3.d5 = WDOT'(r_s2.pd5.x) + WDOT'(r_s2.pd5.y) + WDOT'(r_s2.pd5.z);
        n_s3.d6 = WDOT'(r_s2.pd6.x) + WDOT'(r_s2.pd6.y) + WDOT'(r_s2.pd6.z);
    end

    // Stage 4: half-width partial products of the dot-product pairs for the cross terms.
    always_comb begin
        n_s4p.a   = r_s3.a;
        n_s4p.b   = r_s3.b;
        n_s4p.c   = r_s3.c;
        n_s4p.ab  = r_s3.ab;
        n_s4p.ac  = r_s3.ac;
        n_s4p.bc  = r_s3.bc;
        n_s4p.d1  = r_s3.d1;
        n_s4p.d2  = r_s3.d2;
        n_s4p.d3  = r_s3.d3;
        n_s4p.d4  = r_s3.d4;
        n_s4p.d5  = r_s3.d5;
        n_s4p.d6  = r_s3.d6;
        n_s4p.p14 = split_mul(r_s3.d1, r_s3.d4);
        n_s4p.p32 = split_mul(r_s3.d3, r_s3.d2);
        n_s4p.p52 = split_mul(r_s3.d5, r_s3.d2);
        n_s4p.p16 = split_mul(r_s3.d1, r_s3.d6);
        n_s4p.p36 = split_mul(r_s3.d3, r_s3.d6);
        n_s4p.p54 = split_mul(r_s3.d5, r_s3.d4);
    end

    // Stage 5: add the partial products into the full products of dot products.
    always_comb begin
        n_s4.a   = r_s4p.a;
        n_s4.b   = r_s4p.b;
        n_s4.c   = r_s4p.c;
        n_s4.ab  = r_s4p.ab;
        n_s4.ac  = r_s4p.ac;
        n_s4.bc  = r_s4p.bc;
        n_s4.d1  = r_s4p.d1;
        n_s4.d2  = r_s4p.d2;
        n_s4.d3  = r_s4p.d3;
        n_s4.d4  = r_s4p.d4;
        n_s4.d5  = r_s4p.d5;
        n_s4.d6  = r_s4p.d6;
        n_s4.m14 = join_pp(r_s4p.p14);
        n_s4.m32 = join_pp(r_s4p.p32);
        n_s4.m52 = join_pp(r_s4p.p52);
        n_s4.m16 = join_pp(r_s4p.p16);
        n_s4.m36 = join_pp(r_s4p.p36);
        n_s4.m54 = join_pp(r_s4p.p54);
    end

    // Stage 6: cross terms and the edge bc differences.
    always_comb begin
        n_s5.a   = r_s4.a;
        n_s5.b   = r_s4.b;
        n_s5.c   = r_s4.c;
        n_s5.ab  = r_s4.ab;
        n_s5.ac  = r_s4.ac;
        n_s5.bc  = r_s4.bc;
        n_s5.d1  = r_s4.d1;
        n_s5.d2  = r_s4.d2;
        n_s5.d3  = r_s4.d3;
        n_s5.d6  = r_s4.d6;
        n_s5.t43 = WT'(r_s4.d4) - WT'(r_s4.d3);
        n_s5.t56 = WT'(r_s4.d5) - WT'(r_s4.d6);
        n_s5.vc  = r_s4.m14 - r_s4.m32;
        n_s5.vb  = r_s4.m52 - r_s4.m16;
        n_s5.va  = r_s4.m36 - r_s4.m54;
    end

    // Stage 7: region tests in priority order; set up the ratio numerators and denominator.
    always_comb begin
        logic [WN-1:0] den_ab;
        logic [WN-1:0] den_ac;
        logic [WN-1:0] den_bc;
        logic [WN-1:0] den_f;
        den_ab = WN'(r_s5.d1) - WN'(r_s5.d3);
        den_ac = WN'(r_s5.d2) - WN'(r_s5.d6);
        den_bc = WN'(r_s5.t43) + WN'(r_s5.t56);
        den_f  = WN'(r_s5.va) + WN'(r_s5.vb) + WN'(r_s5.vc);

        n_dv[0].region = REG_A;
        n_dv[0].deg    = 1'b0;
        n_dv[0].base   = r_s5.a;
        n_dv[0].e1     = '0;
        n_dv[0].e2     = '0;
        n_dv[0].den    = WN'(1);
        n_dv[0].rem1   = '0;
        n_dv[0].rem2   = '0;
        n_dv[0].q1     = '0;
        n_dv[0].q2     = '0;

        if (r_s5.d1 <= 0 && r_s5.d2 <= 0) begin
            n_dv[0].region = REG_A;
        end else if (r_s5.d3 >= 0 && r_s5.t43 <= 0) begin
            n_dv[0].region = REG_B;
            n_dv[0].base   = r_s5.b;
        end else if (r_s5.vc <= 0 && r_s5.d1 >= 0 && r_s5.d3 <= 0) begin
            if (den_ab == '0) begin
                n_dv[0].deg = 1'b1;
            end else begin
                n_dv[0].region = REG_AB;
                n_dv[0].e1     = r_s5.ab;
                n_dv[0].rem1   = WN'(r_s5.d1);
                n_dv[0].den    = den_ab;
            end
        end else if (r_s5.d6 >= 0 && r_s5.t56 <= 0) begin
            n_dv[0].region = REG_C;
            n_dv[0].base   = r_s5.c;
        end else if (r_s5.vb <= 0 && r_s5.d2 >= 0 && r_s5.d6 <= 0) begin
            if (den_ac == '0) begin
                n_dv[0].deg = 1'b1;
            end else begin
                n_dv[0].region = REG_AC;
                n_dv[0].e1     = r_s5.ac;
                n_dv[0].rem1   = WN'(r_s5.d2);
                n_dv[0].den    = den_ac;
            end
        end else if (r_s5.va <= 0 && r_s5.t43 >= 0 && r_s5.t56 >= 0) begin
            if (den_bc == '0) begin
                n_dv[0].deg = 1'b1;
            end else begin
                n_dv[0].region = REG_BC;
                n_dv[0].base   = r_s5.b;
                n_dv[0].e1     = r_s5.bc;
                n_dv[0].rem1   = WN'(r_s5.t43);
                n_dv[0].den    = den_bc;
            end
        end else begin
            if (den_f == '0) begin
                n_dv[0].deg = 1'b1;
            end else begin
                n_dv[0].region = REG_FACE;
                n_dv[0].e1     = r_s5.ab;
                n_dv[0].e2     = r_s5.ac;
                n_dv[0].rem1   = WN'(r_s5.vb);
                n_dv[0].rem2   = WN'(r_s5.vc);
                n_dv[0].den    = den_f;
            end
        end
    end

    // Divider: the first step gives the integer bit, the rest one fraction bit each.
    for (genvar j = 1; j <= QB; j++) begin : g_div
        assign n_dv[j] = div_step(r_dv[j-1], (j > 1) ? 1'b1 : 1'b0);
    end

    // Ratio times edge vector, for both ratios.
    always_comb begin
        n_ml.region = r_dv[QB].region;
        n_ml.deg    = r_dv[QB].deg;
        n_ml.base   = r_dv[QB].base;
        n_ml.p1.x   = WM'($signed({1'b0, r_dv[QB].q1})) * WM'(r_dv[QB].e1.x);
        n_ml.p1.y   = WM'($signed({1'b0, r_dv[QB].q1})) * WM'(r_dv[QB].e1.y);
        n_ml.p1.z   = WM'($signed({1'b0, r_dv[QB].q1})) * WM'(r_dv[QB].e1.z);
        n_ml.p2.x   = WM'($signed({1'b0, r_dv[QB].q2})) * WM'(r_dv[QB].e2.x);
        n_ml.p2.y   = WM'($signed({1'b0, r_dv[QB].q2})) * WM'(r_dv[QB].e2.y);
        n_ml.p2.z   = WM'($signed({1'b0, r_dv[QB].q2})) * WM'(r_dv[QB].e2.z);
    end

    // Add to the scaled base vertex, round and saturate.
    always_comb begin
        n_out.region = r_ml.region;
        n_out.deg    = r_ml.deg;
        n_out.near.x = sat_round((WS'(r_ml.base.x) <<< CFB) + WS'(r_ml.p1.x) + WS'(r_ml.p2.x));
        n_out.near.y = sat_round((WS'(r_ml.base.y) <<< CFB) + WS'(r_ml.p1.y) + WS'(r_ml.p2.y));
        n_out.near.z = sat_round((WS'(r_ml.base.z) <<< CFB) + WS'(r_ml.p1.z) + WS'(r_ml.p2.z));
    end

    // Data registers, each loaded when its stage advances.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1 <= n_s1;
        end
        if (en[1]) begin
            r_s2 <= n_s2;
        end
        if (en[2]) begin
            r_s3 <= n_s3;
        end
        if (en[3]) begin
            r_s4p <= n_s4p;
        end
        if (en[4]) begin
            r_s4 <= n_s4;
        end
        if (en[5]) begin
            r_s5 <= n_s5;
        end
        for (int j = 0; j <= QB; j++) begin
            if (en[ST_DV0 + j]) begin
                r_dv[j] <= n_dv[j];
            end
        end
        if (en[ST_MUL]) begin
            r_ml <= n_ml;
        end
        if (en[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid      = r_vld[NST-1];
    assign o_res.near_x     = r_out.near.x;
    assign o_res.near_y     = r_out.near.y;
    assign o_res.near_z     = r_out.near.z;
    assign o_res.region     = r_out.region;
    assign o_res.degenerate = r_out.deg;

    // A degenerate triangle always reports vertex a.
    `CPT_ASSERT_IMP(a_deg_region, i_clk, i_rst_n, o_res.valid && o_res.degenerate, o_res.region == REG_A, "degenerate result not in region a")
    // With every stage full and the output stalled, no item may enter.
    `CPT_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, ($countones(r_vld) == NST) && !o_res.ready, !i_item.ready, "item accepted into a full pipeline")
    // An accepted item occupies the first stage in the next cycle.
    `CPT_ASSERT_NXT(a_accept_load, i_clk, i_rst_n, i_item.valid && i_item.ready, r_vld[0], "accepted item lost at the first stage")

endmodule
